### hdl/acg_pkg.sv
// Package: shared types, codes and widths for the actuator command guard.
`default_nettype none

package acg_pkg;

    localparam int REV_W   = 64;
    localparam int SESS_W  = 32;
    localparam int LEASE_W = 32;
    localparam int TIME_W  = 64;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 1;

    // Operation codes; code 3 is unused and answers all zero.
    typedef enum logic [1:0] {
        CMD_EVAL  = 2'd0,
        CMD_BLOCK = 2'd1,
        CMD_QUERY = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        DEC_OFF    = 2'd0,
        DEC_ON     = 2'd1,
        DEC_RENEW  = 2'd2,
        DEC_REJECT = 2'd3
    } decision_t;

    typedef enum logic [3:0] {
        RSN_OK          = 4'd0,
        RSN_BAD_STATE   = 4'd1,
        RSN_BAD_LEASE   = 4'd2,
        RSN_BAD_SESSION = 4'd3,
        RSN_UNSYNCED    = 4'd4,
        RSN_HANDSHAKE   = 4'd5,
        RSN_SKEW        = 4'd6,
        RSN_STALE       = 4'd7,
        RSN_REBOOT      = 4'd8,
        RSN_CONFLICT    = 4'd9,
        RSN_FAULT       = 4'd10
    } reason_t;

    // Requested output state codes.
    localparam logic [7:0] ST_OFF = 8'd0;
    localparam logic [7:0] ST_ON  = 8'd1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SKEW  = 1'b1;

    typedef struct packed {
        logic [1:0]                command;
        logic [7:0]                cmd_state;
        logic [REV_W-1:0]          revision;
        logic [SESS_W-1:0]         sess_id;
        logic [31:0]               target_cnt;
        logic [LEASE_W-1:0]        lease_len;
        logic signed [TIME_W-1:0]  server_ts;
        logic signed [TIME_W-1:0]  local_ts;
        logic                      clock_synced;
        logic                      feedback_off;
    } in_item_t;

    typedef struct packed {
        logic [1:0] decision;
        logic [3:0] reason;
        logic       persist_flag;
        logic       may_clear_fault;
    } out_item_t;

    typedef struct packed {
        logic [REV_W-1:0]  persisted_rev;
        logic [REV_W-1:0]  blocked_rev;
        logic              off_seen;
        logic              run_valid;
        logic [REV_W-1:0]  run_rev;
        logic              run_on;
        logic [SESS_W-1:0] run_session;
    } guard_state_t;

    typedef struct packed {
        logic [CFG_W-1:0] max_lease;
        logic [CFG_W-1:0] max_skew;
    } guard_cfg_t;

endpackage

`default_nettype wire

### hdl/acg_eval.sv
// Combinational command check, block and query logic with next guard state.
`default_nettype none

module acg_eval (
    input  wire acg_pkg::in_item_t     item,
    input  wire acg_pkg::guard_state_t state,
    input  wire acg_pkg::guard_cfg_t   cfg,
    output acg_pkg::out_item_t         result,
    output acg_pkg::guard_state_t      state_next
);
    import acg_pkg::*;

    logic                 time_ge;
    logic [TIME_W-1:0]    skew_mag;
    logic                 skew_bad;
    logic                 is_off;
    decision_t            dec;
    reason_t              rsn;
    logic                 pers;
    logic                 rev_ge_new;

    // Exact |server - local|: pick the non-negative difference, fits 64 bits.
    assign time_ge  = $signed(item.server_ts) >= $signed(item.local_ts);
    assign skew_mag = time_ge ? (item.server_ts - item.local_ts)
                              : (item.local_ts - item.server_ts);
    assign skew_bad = skew_mag > {{(TIME_W-CFG_W){1'b0}}, cfg.max_skew};
    assign is_off   = (item.cmd_state == ST_OFF);

    // Priority-ordered checks.
    always_comb
    begin
        dec  = DEC_REJECT;
        rsn  = RSN_OK;
        pers = 1'b0;
        if (item.cmd_state > ST_ON)
            rsn = RSN_BAD_STATE;
        else if (is_off)
        begin
            if (item.lease_len != '0)
                rsn = RSN_BAD_LEASE;
            else
            begin
                dec  = DEC_OFF;
                pers = item.revision > state.persisted_rev;
            end
        end
        else if (item.revision == '0 || item.sess_id == '0 || item.target_cnt == '0)
            rsn = RSN_BAD_SESSION;
        else if (item.lease_len == '0 || item.lease_len > cfg.max_lease)
            rsn = RSN_BAD_LEASE;
        else if (!item.clock_synced)
            rsn = RSN_UNSYNCED;
        else if (!state.off_seen)
            rsn = RSN_HANDSHAKE;
        else if (skew_bad)
            rsn = RSN_SKEW;
        else if (item.revision < state.persisted_rev)
            rsn = RSN_STALE;
        else if (item.revision <= state.blocked_rev)
            rsn = RSN_FAULT;
        else if (item.revision == state.persisted_rev)
        begin
            if (!state.run_valid || state.run_rev != item.revision)
                rsn = RSN_REBOOT;
            else if (!state.run_on || state.run_session != item.sess_id)
                rsn = RSN_CONFLICT;
            else
                dec = DEC_RENEW;
        end
        else
        begin
            dec  = DEC_ON;
            pers = 1'b1;
        end
    end

    // pers implies revision above persisted, so the new persisted value is revision.
    assign rev_ge_new = pers || (item.revision >= state.persisted_rev);

    always_comb
    begin
        result     = '0;
        state_next = state;
        case (cmd_t'(item.command))
            CMD_EVAL:
            begin
                result.decision     = dec;
                result.reason       = rsn;
                result.persist_flag = pers;
                if (dec != DEC_REJECT)
                begin
                    if (pers)
                        state_next.persisted_rev = item.revision;
                    if (is_off && rev_ge_new)
                        state_next.off_seen = 1'b1;
                    if (!rev_ge_new)
                    begin
                        if (is_off)
                            state_next.run_valid = 1'b0;
                    end
                    else
                    begin
                        state_next.run_valid   = 1'b1;
                        state_next.run_rev     = item.revision;
                        state_next.run_on      = (item.cmd_state == ST_ON);
                        state_next.run_session = item.sess_id;
                    end
                end
            end
            CMD_BLOCK:
            begin
                if (item.revision > state.blocked_rev)
                    state_next.blocked_rev = item.revision;
            end
            CMD_QUERY:
            begin
                result.may_clear_fault = item.feedback_off
                                         && (item.revision > state.blocked_rev);
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/acg_state.sv
// Guard state and configuration registers.
`default_nettype none

module acg_state (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [acg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [acg_pkg::CFG_W-1:0]       cfg_data,
    input  wire logic                            commit,
    input  wire acg_pkg::guard_state_t           state_next,
    output acg_pkg::guard_state_t                state,
    output acg_pkg::guard_cfg_t                  cfg
);
    import acg_pkg::*;

    guard_state_t state_reg;
    guard_cfg_t   cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (commit)
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_LEASE: cfg_reg.max_lease <= cfg_data;
                CFG_MAX_SKEW:  cfg_reg.max_skew  <= cfg_data;
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign state = state_reg;
    assign cfg   = cfg_reg;

endmodule

`default_nettype wire

### hdl/actuator_command_guard.sv
// Top level: input register, single-pass guard logic, result register.
`default_nettype none

// Actuator command guard. Each input transfer carries one operation: evaluate
// (check an ON/OFF command in fixed priority order, answer a decision and
// reason, and commit an accepted command to the guard state), block (raise
// the blocked fault revision) or query (may a fault be cleared). Every
// transfer gives exactly one result transfer. Timing: an item lands in the
// input register on its input transfer and is evaluated there; on the edge
// on which it advances, its state update is written and its result is
// loaded into the result register, so the throughput is one item per clock
// while out_stall is low; the rate is set by the single evaluate stage,
// whose state write completes on the same edge that loads the result, so a
// following item always sees updated state.
// in_stall follows out_stall combinationally when both registers are full.
// Configuration (max_lease index 0, max_skew index 1) is written through
// cfg_we/cfg_index/cfg_data and must only change while the block is idle.
module actuator_command_guard (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [acg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [acg_pkg::CFG_W-1:0]       cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire acg_pkg::in_item_t               in_data,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output acg_pkg::out_item_t                   out_data
);
    import acg_pkg::*;

    logic         in_valid_reg;
    logic         in_valid_next;
    in_item_t     in_data_reg;
    logic         out_valid_reg;
    logic         out_valid_next;
    out_item_t    out_data_reg;

    logic         in_xfer;
    logic         advance;
    guard_state_t state;
    guard_state_t state_next;
    guard_cfg_t   cfg;
    out_item_t    result;

    // The held item moves on when the result register is empty or draining.
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_xfer  = in_valid && !in_stall;

    assign in_valid_next  = in_xfer || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            in_data_reg <= in_data;
        if (advance)
            out_data_reg <= result;
    end

    acg_eval u_eval (
        .item       (in_data_reg),
        .state      (state),
        .cfg        (cfg),
        .result     (result),
        .state_next (state_next)
    );

    // State is committed on the same edge the result is captured.
    acg_state u_state (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .commit     (advance),
        .state_next (state_next),
        .state      (state),
        .cfg        (cfg)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef NO_ASSERTIONS
    // Stall toward the source only while an item is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg)
        else $error("in_stall without a held item");

    // A rejected command never asks for persistence.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.decision == DEC_REJECT)
            |-> !out_data_reg.persist_flag)
        else $error("persist_flag on a rejected command");

    // Fault-clear answers carry no decision or reason.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.may_clear_fault)
            |-> (out_data_reg.decision == DEC_OFF && out_data_reg.reason == RSN_OK
                 && !out_data_reg.persist_flag))
        else $error("may_clear_fault mixed with a command result");

    // Persisted and blocked revisions never move backward.
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> state.persisted_rev >= $past(state.persisted_rev))
        else $error("persisted_rev decreased");

    assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> state.blocked_rev >= $past(state.blocked_rev))
        else $error("blocked_rev decreased");
`endif

endmodule

`default_nettype wire

### dv/tb_top.sv
// Self-checking testbench for the actuator command guard: directed and random commands.
`timescale 1ns / 100ps

module tb_top;
    import acg_pkg::*;

    // Unused operation code; the guard answers all zero and keeps its state.
    localparam logic [1:0]  CMD_UNUSED = 2'd3;
    localparam logic [63:0] REV_MAX    = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] TIME_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] TIME_MIN   = 64'h8000_0000_0000_0000;
    localparam int          ITEMS_PER_PHASE = 130;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    in_item_t             in_data = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_item_t            out_data;

    // Commands waiting for the sender, and verdicts waiting for the guard to answer.
    in_item_t  command_q[$];
    out_item_t verdict_q[$];

    // Shadow of the guard: limits and committed state.
    logic [31:0] lim_lease = '0;
    logic [31:0] lim_skew = '0;
    logic [63:0] sh_persisted = '0;
    logic [63:0] sh_blocked = '0;
    logic        sh_off_seen = 1'b0;
    logic        sh_run_valid = 1'b0;
    logic [63:0] sh_run_rev = '0;
    logic        sh_run_on = 1'b0;
    logic [31:0] sh_run_session = '0;

    // Stimulus bookkeeping: rough idea of where the revisions stand.
    logic [63:0] gen_rev = '0;
    logic [63:0] gen_blocked = '0;
    logic [31:0] gen_lease = '0;
    logic [31:0] gen_skew = '0;
    int          phase_items;

    // Idling state for both sides.
    int   gap_left = 0;
    int   hold_left = 0;
    bit   send_steady = 1'b0;
    bit   recv_steady = 1'b0;
    bit   pressure_done = 1'b0;
    int   results_seen = 0;
    int   errors = 0;

    actuator_command_guard u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Verdict predictor. Runs once per accepted transfer, in order, so the
    // shadow state always matches what the guard has committed.
    // ------------------------------------------------------------------
    task automatic guard_verdict(input in_item_t it, output out_item_t res);
        decision_t   dec;
        reason_t     rsn;
        logic        pers;
        logic [64:0] diff;
        logic [64:0] skew_mag;
        res = '0;
        case (it.command)
            CMD_EVAL:
            begin
                dec  = DEC_REJECT;
                rsn  = RSN_OK;
                pers = 1'b0;
                // Exact server - local difference on 65 bits, then its magnitude.
                diff = {it.server_ts[63], it.server_ts}
                       - {it.local_ts[63], it.local_ts};
                skew_mag = diff[64] ? (~diff + 65'd1) : diff;
                if (it.cmd_state > ST_ON)
                    rsn = RSN_BAD_STATE;
                else if (it.cmd_state == ST_OFF)
                begin
                    // OFF only needs a zero lease; everything else is ignored.
                    if (it.lease_len != '0)
                        rsn = RSN_BAD_LEASE;
                    else
                    begin
                        dec  = DEC_OFF;
                        pers = it.revision > sh_persisted;
                    end
                end
                else if (it.revision == '0 || it.sess_id == '0 || it.target_cnt == '0)
                    rsn = RSN_BAD_SESSION;
                else if (it.lease_len == '0 || it.lease_len > lim_lease)
                    rsn = RSN_BAD_LEASE;
                else if (!it.clock_synced)
                    rsn = RSN_UNSYNCED;
                else if (!sh_off_seen)
                    rsn = RSN_HANDSHAKE;
                else if (skew_mag > {33'd0, lim_skew})
                    rsn = RSN_SKEW;
                else if (it.revision < sh_persisted)
                    rsn = RSN_STALE;
                else if (it.revision <= sh_blocked)
                    rsn = RSN_FAULT;
                else if (it.revision == sh_persisted)
                begin
                    // Same revision again: only a renew of the running ON session.
                    if (!sh_run_valid || sh_run_rev != it.revision)
                        rsn = RSN_REBOOT;
                    else if (!sh_run_on || sh_run_session != it.sess_id)
                        rsn = RSN_CONFLICT;
                    else
                        dec = DEC_RENEW;
                end
                else
                begin
                    dec  = DEC_ON;
                    pers = 1'b1;
                end

                res.decision     = dec;
                res.reason       = rsn;
                res.persist_flag = pers;

                // Commit accepted commands; rejects leave the state alone.
                if (dec != DEC_REJECT)
                begin
                    if (pers && it.revision > sh_persisted)
                        sh_persisted = it.revision;
                    if (it.cmd_state == ST_OFF && it.revision >= sh_persisted)
                        sh_off_seen = 1'b1;
                    if (it.revision < sh_persisted)
                    begin
                        if (it.cmd_state == ST_OFF)
                            sh_run_valid = 1'b0;
                    end
                    else
                    begin
                        sh_run_valid   = 1'b1;
                        sh_run_rev     = it.revision;
                        sh_run_on      = it.cmd_state == ST_ON;
                        sh_run_session = it.sess_id;
                    end
                end
            end
            CMD_BLOCK:
            begin
                if (it.revision > sh_blocked)
                    sh_blocked = it.revision;
            end
            CMD_QUERY:
                res.may_clear_fault = it.feedback_off && it.revision > sh_blocked;
            default:
                ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Idle patterns: mostly short gaps, a few long ones, and stretches
    // where a side does not idle at all.
    // ------------------------------------------------------------------
    function automatic int next_gap();
        int r;
        if ($urandom_range(0, 39) == 0)
            send_steady = !send_steady;
        if (send_steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int next_stall();
        int r;
        if ($urandom_range(0, 63) == 0)
            recv_steady = !recv_steady;
        if (recv_steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    // ------------------------------------------------------------------
    // Sender: presents queued commands, keeps the payload steady while
    // stalled, predicts each accepted transfer.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : sender
        out_item_t want;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                guard_verdict(in_data, want);
                verdict_q.push_back(want);
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (command_q.size() > 0)
                begin
                    in_data  <= command_q.pop_front();
                    in_valid <= 1'b1;
                    gap_left = next_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: checks each result transfer against the oldest verdict
    // and drives stall. Once, mid run, it holds off long enough for the
    // guard to back up and stall its input.
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [3:0] want,
                               input logic [3:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : receiver
        out_item_t want;
        int        len;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (verdict_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, out_data);
                    errors++;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    check_field("decision", 4'(want.decision), 4'(out_data.decision));
                    check_field("reason", want.reason, out_data.reason);
                    check_field("persist_flag", 4'(want.persist_flag),
                                4'(out_data.persist_flag));
                    check_field("may_clear_fault", 4'(want.may_clear_fault),
                                4'(out_data.may_clear_fault));
                end
                if (results_seen == 300 && !pressure_done)
                begin
                    hold_left     = 150;
                    pressure_done = 1'b1;
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                len = next_stall();
                out_stall <= (len > 0);
                if (len > 0)
                    hold_left = len - 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus builders.
    // ------------------------------------------------------------------
    function automatic in_item_t mk_item(logic [1:0] op, logic [7:0] st, logic [63:0] rev,
                                         logic [31:0] sess, logic [31:0] tgt,
                                         logic [31:0] lease, logic [63:0] srv,
                                         logic [63:0] loc, logic sync, logic fb);
        in_item_t it;
        it.command      = op;
        it.cmd_state    = st;
        it.revision     = rev;
        it.sess_id      = sess;
        it.target_cnt   = tgt;
        it.lease_len    = lease;
        it.server_ts    = srv;
        it.local_ts     = loc;
        it.clock_synced = sync;
        it.feedback_off = fb;
        return it;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // ON command that passes every field check under the current limits, unless the lease limit is zero.
    function automatic in_item_t good_on(logic [63:0] rev, logic [31:0] sess);
        logic [63:0] loc;
        logic [63:0] d;
        logic [31:0] bound;
        logic [31:0] lease;
        loc   = $signed(rand64()) >>> 2;
        bound = (gen_skew > 32'd1000) ? 32'd1000 : gen_skew;
        d     = 64'($urandom_range(bound, 0));
        if ($urandom_range(0, 15) == 0)
            d = {32'd0, gen_skew};
        if (gen_lease == '0)
            lease = $urandom_range(1, 50);
        else if ($urandom_range(0, 7) == 0)
            lease = gen_lease;
        else
            lease = $urandom_range(1, (gen_lease > 32'd5000) ? 32'd5000 : gen_lease);
        return mk_item(CMD_EVAL, ST_ON, rev, sess, $urandom_range(1, 100), lease,
                       $urandom_range(0, 1) ? loc + d : loc - d, loc, 1'b1,
                       1'($urandom_range(0, 1)));
    endfunction

    function automatic in_item_t good_off(logic [63:0] rev);
        return mk_item(CMD_EVAL, ST_OFF, rev, $urandom, $urandom, '0, rand64(), rand64(),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endfunction

    // Next revision above everything issued or blocked so far.
    function automatic logic [63:0] fresh_rev();
        if (gen_blocked > gen_rev)
            gen_rev = gen_blocked;
        gen_rev += 64'd1;
        if ($urandom_range(0, 3) == 0)
            gen_rev += 64'($urandom_range(1, 5));
        return gen_rev;
    endfunction

    function automatic logic [63:0] older_rev();
        return (gen_rev > 64'd3) ? gen_rev - $urandom_range(1, 3) : 64'd0;
    endfunction

    task automatic queue_cmd(input in_item_t it);
        command_q.push_back(it);
        phase_items++;
    endtask

    task automatic apply_cfg(input logic [31:0] lease, input logic [31:0] skew);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MAX_LEASE;
        cfg_data  <= lease;
        @(posedge clk);
        cfg_index <= CFG_MAX_SKEW;
        cfg_data  <= skew;
        @(posedge clk);
        cfg_we    <= 1'b0;
        lim_lease = lease;
        lim_skew  = skew;
        gen_lease = lease;
        gen_skew  = skew;
    endtask

    // Every transfer answers, so idle means: nothing queued, nothing offered,
    // nothing outstanding, then let the input and result registers settle.
    task automatic wait_idle();
        while (command_q.size() != 0 || in_valid || verdict_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One random sequence, mostly well formed so the deep checks get reached.
    task automatic random_burst();
        in_item_t    it;
        logic [31:0] sess;
        logic [7:0]  st;
        logic [63:0] rv;
        int          kind;
        int          n;
        kind = $urandom_range(0, 99);
        sess = $urandom | 32'd1;
        if (kind < 40)
        begin
            // Handshake OFF, ON, a few renews, maybe a foreign session, then wind down.
            queue_cmd(good_off(fresh_rev()));
            rv = fresh_rev();
            queue_cmd(good_on(rv, sess));
            n = $urandom_range(0, 3);
            repeat (n) queue_cmd(good_on(rv, sess));
            if ($urandom_range(0, 3) == 0)
                queue_cmd(good_on(rv, sess ^ ($urandom | 32'd1)));
            case ($urandom_range(0, 2))
                0: queue_cmd(good_off(rv));
                1:
                begin
                    // Old OFF drops the running session: a retry is a reboot.
                    queue_cmd(good_off(older_rev()));
                    queue_cmd(good_on(rv, sess));
                end
                default: ;
            endcase
        end
        else if (kind < 55)
        begin
            // Raise the fault revision, then probe just around it.
            gen_blocked = gen_rev + $urandom_range(0, 2);
            queue_cmd(mk_item(CMD_BLOCK, 8'($urandom), gen_blocked, $urandom, $urandom,
                              $urandom, rand64(), rand64(), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1))));
            queue_cmd(good_on(gen_blocked - $urandom_range(0, 1), sess));
            queue_cmd(mk_item(CMD_QUERY, 8'($urandom),
                              gen_blocked + $urandom_range(0, 2) - 64'd1,
                              $urandom, $urandom, $urandom, rand64(), rand64(),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
        end
        else if (kind < 65)
            queue_cmd(good_on(older_rev(), sess));
        else if (kind < 80)
        begin
            // Well formed ON with exactly one check broken.
            it = good_on(gen_rev + 64'd1, sess);
            case ($urandom_range(0, 7))
                0: it.cmd_state = 8'($urandom_range(2, 255));
                1: it.revision = '0;
                2: it.sess_id = '0;
                3: it.target_cnt = '0;
                4: it.lease_len = '0;
                5: it.lease_len = gen_lease + 32'd1;
                6: it.clock_synced = 1'b0;
                default: it.server_ts = it.local_ts + gen_skew + 64'd1
                                        + $urandom_range(0, 100);
            endcase
            queue_cmd(it);
        end
        else
        begin
            // Noise over the full field ranges; evaluates are kept from committing.
            n = $urandom_range(0, 9);
            st = $urandom_range(0, 1) ? 8'($urandom) : ($urandom_range(0, 1) ? ST_ON : ST_OFF);
            it = mk_item(CMD_EVAL, st, rand64(), $urandom, $urandom, $urandom, rand64(),
                         rand64(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            if (n >= 9)
                it.command = CMD_UNUSED;
            else if (n >= 7)
                it.command = CMD_QUERY;
            else if (st == ST_ON)
                it.clock_synced = 1'b0;
            else if (st == ST_OFF && it.lease_len == '0)
                it.lease_len = 32'd1;
            queue_cmd(it);
        end
    endtask

    // ------------------------------------------------------------------
    // Run: reset, directed commands, random phases under several limit
    // settings, revision extremes at the very end.
    // ------------------------------------------------------------------
    initial
    begin : run
        logic [31:0] lease_set[5];
        logic [31:0] skew_set[5];
        lease_set = '{32'hFFFF_FFFF, 32'd0, 32'd2000, 32'd1, 32'd0};
        skew_set  = '{32'hFFFF_FFFF, 32'd0, 32'd40, 32'hFFFF_FFFF, 32'd0};
        lease_set[4] = $urandom;
        skew_set[4]  = $urandom;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        apply_cfg(32'd1000, 32'd5);
        // Fault clear with nothing blocked yet: needs a revision above zero.
        queue_cmd(mk_item(CMD_QUERY, ST_OFF, 64'd0, 0, 0, 0, 0, 0, 1'b0, 1'b1));
        queue_cmd(mk_item(CMD_QUERY, ST_OFF, 64'd1, 0, 0, 0, 0, 0, 1'b0, 1'b1));
        // ON before any OFF handshake.
        queue_cmd(mk_item(CMD_EVAL, ST_ON, 64'd5, 7, 3, 500, 0, 0, 1'b1, 1'b0));
        // Invalid state wins over every other field, all at their extremes.
        queue_cmd(mk_item(CMD_EVAL, 8'hFF, REV_MAX, '1, '1, '1, TIME_MAX, TIME_MIN,
                          1'b1, 1'b1));
        queue_cmd(mk_item(CMD_EVAL, ST_OFF, 64'd10, 0, 0, 1, 0, 0, 1'b0, 1'b0));
        queue_cmd(mk_item(CMD_EVAL, ST_OFF, 64'd10, 0, 0, 0, 0, 0, 1'b0, 1'b0));
        // Field checks of an ON command in priority order.
        queue_cmd(mk_item(CMD_EVAL, ST_ON, 64'd0, 7, 3, 500, 0, 0, 1'b1, 1'b0));
        queue_cmd(mk_item(CMD_EVAL, ST_ON, 64'd30, 0, 3, 500, 0, 0, 1'b1, 1'b0));
        queue_cmd(mk_item(CMD_EVAL, ST_ON, 64'd30, 7, 0, 500, 0, 0, 1'b1, 1'b0));
        queue_cmd(mk_item(CMD_EVAL, ST_ON, 64'd30, 7, 3, 0, 0, 0, 1'b1, 1'b0));
        queue_cmd(mk_item(CMD_EVAL, ST_ON, 64'd30, 7, 3, 1001, 0, 0, 1'b1, 1'b0));
        queue_cmd(mk_item(CMD_EVAL, ST_ON, 64'd30, 7, 3, 500, 0, 0, 1'b0, 1'b0));
        queue_cmd(mk_item(CMD_EVAL, ST_ON, 64'd30, 7, 3, 500, 6, 0, 1'b1, 1'b0));
        // Widest possible skew: must not wrap into a small value.
        queue_cmd(mk_item(CMD_EVAL, ST_ON, 64'd30, 7, 3, 500, TIME_MAX, TIME_MIN,
                          1'b1, 1'b0));
        queue_cmd(mk_item(CMD_EVAL, ST_ON, 64'd5, 7, 3, 500, 0, 0, 1'b1, 1'b0));
        // Blocked revision and the fault check at its boundary.
        queue_cmd(mk_item(CMD_BLOCK, ST_OFF, 64'd20, 0, 0, 0, 0, 0, 1'b0, 1'b0));
        queue_cmd(mk_item(CMD_EVAL, ST_ON, 64'd20, 7, 3, 500, 0, 0, 1'b1, 1'b0));
        // Accepted ON at the lease limit and skew limit, then renew and conflict.
        queue_cmd(mk_item(CMD_EVAL, ST_ON, 64'd21, 7, 3, 1000, -64'sd5, 0, 1'b1, 1'b0));
        queue_cmd(mk_item(CMD_EVAL, ST_ON, 64'd21, 7, 3, 500, 0, 0, 1'b1, 1'b0));
        queue_cmd(mk_item(CMD_EVAL, ST_ON, 64'd21, 8, 3, 500, 0, 0, 1'b1, 1'b0));
        // OFF at the same revision stops the session: renew becomes a conflict.
        queue_cmd(mk_item(CMD_EVAL, ST_OFF, 64'd21, 0, 0, 0, 0, 0, 1'b1, 1'b0));
        queue_cmd(mk_item(CMD_EVAL, ST_ON, 64'd21, 7, 3, 500, 0, 0, 1'b1, 1'b0));
        // Stale OFF invalidates the running record: retry is a reboot.
        queue_cmd(mk_item(CMD_EVAL, ST_OFF, 64'd3, 0, 0, 0, 0, 0, 1'b1, 1'b0));
        queue_cmd(mk_item(CMD_EVAL, ST_ON, 64'd21, 7, 3, 500, 0, 0, 1'b1, 1'b0));
        queue_cmd(mk_item(CMD_QUERY, ST_OFF, 64'd21, 0, 0, 0, 0, 0, 1'b0, 1'b0));
        queue_cmd(mk_item(CMD_UNUSED, 8'hFF, REV_MAX, '1, '1, '1, '1, '1, 1'b1, 1'b1));
        wait_idle();
        gen_rev     = 64'd100;
        gen_blocked = 64'd20;

        for (int p = 0; p < 5; p++)
        begin
            apply_cfg(lease_set[p], skew_set[p]);
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE)
                random_burst();
            wait_idle();
        end

        // Revision extremes last, since they pin the guard state for good.
        apply_cfg(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_cmd(good_off(REV_MAX));
        queue_cmd(good_on(REV_MAX, 32'hFFFF_FFFF));
        queue_cmd(mk_item(CMD_BLOCK, ST_OFF, REV_MAX, 0, 0, 0, 0, 0, 1'b0, 1'b0));
        queue_cmd(mk_item(CMD_QUERY, ST_OFF, REV_MAX, 0, 0, 0, 0, 0, 1'b0, 1'b1));
        wait_idle();
        repeat (10) @(posedge clk);

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial
    begin : watchdog
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

### actuator_command_guard.f
hdl/acg_pkg.sv
hdl/acg_eval.sv
hdl/acg_state.sv
hdl/actuator_command_guard.sv
dv/tb_top.sv
